[sv/mcrd_pkg.sv]
// shared types, codes and constants for the multi-channel rate divider
package mcrd_pkg;

  localparam int unsigned MCRD_MAX_CHANNELS = 16;
  localparam logic [7:0]  BASE_RATE_RESET   = 8'd200;

  // request commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // cell load select
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD       = 2'd0;
  localparam cell_op_t CELL_FROM_LOWER = 2'd1;  // move toward the back of the list
  localparam cell_op_t CELL_FROM_UPPER = 2'd2;  // move toward the front of the list

  typedef struct packed {
    logic       used;
    logic [7:0] handle;
    logic [7:0] rate;
    logic [7:0] count;
  } entry_t;

endpackage

[sv/mcrd_cell.sv]
// one list cell: holds one channel entry and loads from either neighbor
module mcrd_cell (
  input  logic            clk,
  input  logic            rst,
  input  mcrd_pkg::cell_op_t op,
  input  mcrd_pkg::entry_t  from_lower,
  input  mcrd_pkg::entry_t  from_upper,
  output mcrd_pkg::entry_t  q
);
  import mcrd_pkg::*;

  entry_t entry;
  entry_t entry_next;

  always_comb begin
    case (op)
      CELL_FROM_LOWER: entry_next = from_lower;
      CELL_FROM_UPPER: entry_next = from_upper;
      default:         entry_next = entry;
    endcase
  end

  // only the used bit is control state, the payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.used <= 1'b0;
    end else begin
      entry.used <= entry_next.used;
    end
    entry.handle <= entry_next.handle;
    entry.rate   <= entry_next.rate;
    entry.count  <= entry_next.count;
  end

  assign q = entry;

endmodule

[sv/multi_channel_rate_divider.sv]
// top level of the multi-channel rate divider: cell chain, sequencer and result register
//
//   channel   ports                                        direction
//   --------  -------------------------------------------  ---------
//   request   start, busy, command, handle, rate           in (busy out)
//   result    strobe, status, fired, fired_handle,         out
//             tick_count, last
//   config    cfg_we, cfg_wdata (base_rate)                in
//
// add and clear requests need no rotation: the result strobes in the cycle
// after the request and busy stays low, so requests of this kind may follow
// back to back. tick and remove rotate the whole chain once, one cell a cycle,
// through the front cell: busy stays high through the rotation and the closing
// state (ST_TFIN or ST_RFIN), and the next request is taken back in ST_IDLE.
// tick results come out during the rotation, at most one per cycle, the final
// one registered from ST_TFIN after it. synchronous reset clears the used bits, the tick
// count and the state, and loads base_rate with 200; no clearing pass is needed.
// the receiver cannot stall: each result is on the ports for one cycle only.
module multi_channel_rate_divider #(
  parameter int unsigned MAX_CHANNELS = mcrd_pkg::MCRD_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  handle,
  input  logic [7:0]  rate,
  // result
  output logic        strobe,
  output logic [1:0]  status,
  output logic        fired,
  output logic [7:0]  fired_handle,
  output logic [31:0] tick_count,
  output logic        last,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import mcrd_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_CHANNELS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;  // rotate and update counters
  localparam logic [2:0] ST_TFIN  = 3'd2;  // final tick result
  localparam logic [2:0] ST_RSRCH = 3'd3;  // rotate and look for the handle
  localparam logic [2:0] ST_RFIN  = 3'd4;  // close the gap, report

  logic [2:0]       state;
  logic [IDX_W-1:0] step;
  logic [7:0]       base_rate;
  logic [31:0]      ticks;

  // remove search
  logic [7:0]       target;
  logic             found;
  logic [IDX_W-1:0] found_pos;

  // fired handle held back until we know whether another fire follows
  logic             pend_valid;
  logic [7:0]       pend_handle;

  entry_t   cell_q    [MAX_CHANNELS];
  cell_op_t cell_op   [MAX_CHANNELS];
  entry_t   new_entry;
  entry_t   front_upd;
  entry_t   tail_in;

  logic       accept;
  logic       full;
  logic [8:0] diff;
  logic       front_fire;
  logic       front_hit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign full   = cell_q[MAX_CHANNELS-1].used;

  // entry for an add, enters at the front
  always_comb begin
    new_entry.used   = 1'b1;
    new_entry.handle = handle;
    new_entry.rate   = (rate == 8'd0) ? base_rate : rate;
    new_entry.count  = base_rate;
  end

  // counter update of the front cell on its way to the back
  assign diff       = {1'b0, cell_q[0].count} - {1'b0, cell_q[0].rate};
  assign front_fire = cell_q[0].used && (diff[8] || (diff == 9'd0));
  assign front_hit  = cell_q[0].used && (cell_q[0].handle == target) && !found;

  always_comb begin
    front_upd = cell_q[0];
    if (cell_q[0].used) begin
      front_upd.count = diff[7:0] + (front_fire ? base_rate : 8'd0);
    end
  end

  // what the back cell loads when the chain moves toward the front
  always_comb begin
    case (state)
      ST_TICK:  tail_in = front_upd;
      ST_RSRCH: tail_in = cell_q[0];
      default:  tail_in = '0;  // empty entry closes the list after a remove
    endcase
  end

  // the chain
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    entry_t lower_in;
    entry_t upper_in;

    if (i == 0) begin : g_head
      assign lower_in = new_entry;
    end else begin : g_mid_lower
      assign lower_in = cell_q[i-1];
    end

    if (i == MAX_CHANNELS - 1) begin : g_tail
      assign upper_in = tail_in;
    end else begin : g_mid_upper
      assign upper_in = cell_q[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_ADD) && !full) begin
            cell_op[i] = CELL_FROM_LOWER;
          end
        end
        ST_TICK, ST_RSRCH: begin
          cell_op[i] = CELL_FROM_UPPER;
        end
        ST_RFIN: begin
          // cells from the removed one onward move up by one
          if (found && (IDX_W'(i) >= found_pos)) begin
            cell_op[i] = CELL_FROM_UPPER;
          end
        end
        default: cell_op[i] = CELL_HOLD;
      endcase
    end

    mcrd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op[i]),
      .from_lower (lower_in),
      .from_upper (upper_in),
      .q          (cell_q[i])
    );
  end

  // base rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate <= BASE_RATE_RESET;
    end else if (cfg_we) begin
      base_rate <= cfg_wdata;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      ticks      <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            step       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            case (command)
              CMD_TICK: begin
                ticks <= ticks + 32'd1;
                state <= ST_TICK;
              end
              CMD_REMOVE: begin
                state <= ST_RSRCH;
              end
              CMD_ADD: begin
                strobe       <= 1'b1;
                status       <= full ? STATUS_FULL : STATUS_OK;
                fired        <= 1'b0;
                fired_handle <= 8'd0;
                last         <= 1'b1;
              end
              default: begin
                ticks        <= '0;
                strobe       <= 1'b1;
                status       <= STATUS_OK;
                fired        <= 1'b0;
                fired_handle <= 8'd0;
                last         <= 1'b1;
              end
            endcase
          end
        end
        ST_TICK: begin
          if (front_fire) begin
            // a newer fire means the held one is not the final result
            if (pend_valid) begin
              strobe       <= 1'b1;
              status       <= STATUS_OK;
              fired        <= 1'b1;
              fired_handle <= pend_handle;
              last         <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_handle <= cell_q[0].handle;
          end
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_TFIN;
          end
        end
        ST_TFIN: begin
          strobe       <= 1'b1;
          status       <= STATUS_OK;
          fired        <= pend_valid;
          fired_handle <= pend_valid ? pend_handle : 8'd0;
          last         <= 1'b1;
          pend_valid   <= 1'b0;
          state        <= ST_IDLE;
        end
        ST_RSRCH: begin
          if (front_hit) begin
            found     <= 1'b1;
            found_pos <= step;
          end
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_RFIN;
          end
        end
        ST_RFIN: begin
          strobe       <= 1'b1;
          status       <= found ? STATUS_OK : STATUS_NOT_FOUND;
          fired        <= 1'b0;
          fired_handle <= 8'd0;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // handle of a remove request, compared while the chain rotates
  always_ff @(posedge clk) begin
    if (accept) begin
      target <= handle;
    end
  end

  // tick count holds still from request to its last result
  assign tick_count = ticks;

endmodule
